@@ hw/rtl/stl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, token codes, keyword table and byte classifiers for the lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned KEYWORD_BYTES = 12;
  localparam int unsigned NUM_KEYWORDS  = 22;
  localparam int unsigned MAX_RESULTS   = 6;
  localparam int unsigned NUM_CAND      = 7;
  localparam logic [9:0]  MAX_TOKEN_BYTES = 10'd1023;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] AR_LEAD   = 8'hD8;
  localparam logic [7:0] AR_COMMA  = 8'h8C;
  localparam logic [7:0] AR_SEMI   = 8'h9B;

  localparam logic [5:0] K_INT     = 6'd0;
  localparam logic [5:0] K_FLOAT   = 6'd1;
  localparam logic [5:0] K_STRING  = 6'd2;
  localparam logic [5:0] K_IDENT   = 6'd3;
  localparam logic [5:0] K_KW0     = 6'd4;
  localparam logic [5:0] K_ADD     = 6'd26;
  localparam logic [5:0] K_SUB     = 6'd27;
  localparam logic [5:0] K_MUL     = 6'd28;
  localparam logic [5:0] K_DIV     = 6'd29;
  localparam logic [5:0] K_MOD     = 6'd30;
  localparam logic [5:0] K_POW     = 6'd31;
  localparam logic [5:0] K_EQEQ    = 6'd32;
  localparam logic [5:0] K_NE      = 6'd33;
  localparam logic [5:0] K_LT      = 6'd34;
  localparam logic [5:0] K_GT      = 6'd35;
  localparam logic [5:0] K_LE      = 6'd36;
  localparam logic [5:0] K_GE      = 6'd37;
  localparam logic [5:0] K_ASSIGN  = 6'd38;
  localparam logic [5:0] K_ADDEQ   = 6'd39;
  localparam logic [5:0] K_SUBEQ   = 6'd40;
  localparam logic [5:0] K_MULEQ   = 6'd41;
  localparam logic [5:0] K_DIVEQ   = 6'd42;
  localparam logic [5:0] K_LPAR    = 6'd43;
  localparam logic [5:0] K_RPAR    = 6'd44;
  localparam logic [5:0] K_LBRACE  = 6'd45;
  localparam logic [5:0] K_RBRACE  = 6'd46;
  localparam logic [5:0] K_LBRACK  = 6'd47;
  localparam logic [5:0] K_RBRACK  = 6'd48;
  localparam logic [5:0] K_COMMA   = 6'd49;
  localparam logic [5:0] K_SEMI    = 6'd50;
  localparam logic [5:0] K_COLON   = 6'd51;
  localparam logic [5:0] K_DOT     = 6'd52;
  localparam logic [5:0] K_ARROW   = 6'd53;
  localparam logic [5:0] K_EOF     = 6'd54;
  localparam logic [5:0] K_ERROR   = 6'd55;

  localparam logic REC_VALUE = 1'b0;
  localparam logic REC_END   = 1'b1;

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_NUMBER, M_STRING, M_IDENT, M_OPER
  } mode_t;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic        rec_kind;
    logic [7:0]  value_byte;
    logic [5:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [9:0]  value_length;
    logic        truncated;
    logic        last_result;
  } out_t;

  typedef struct packed {
    out_t [MAX_RESULTS-1:0] slot;
    logic [2:0]             cnt;
  } job_t;

  typedef logic [7:0] kwbuf_t [KEYWORD_BYTES];

  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd10, 4'd8, 4'd8, 4'd8, 4'd6, 4'd8, 4'd10, 4'd6, 4'd4, 4'd8, 4'd10,
    4'd6, 4'd8, 4'd6, 4'd12, 4'd6, 4'd8, 4'd6, 4'd8, 4'd2, 4'd4, 4'd6
  };

  localparam logic [7:0] KW_TABLE [NUM_KEYWORDS][KEYWORD_BYTES] = '{
    '{8'hD9,8'h85,8'hD8,8'hAA,8'hD8,8'hBA,8'hD9,8'h8A,8'hD8,8'hB1,8'h00,8'h00},
    '{8'hD8,8'hAB,8'hD8,8'hA7,8'hD8,8'hA8,8'hD8,8'hAA,8'h00,8'h00,8'h00,8'h00},
    '{8'hD8,8'hAF,8'hD8,8'hA7,8'hD9,8'h84,8'hD8,8'hA9,8'h00,8'h00,8'h00,8'h00},
    '{8'hD8,8'hA3,8'hD8,8'hB1,8'hD8,8'hAC,8'hD8,8'hB9,8'h00,8'h00,8'h00,8'h00},
    '{8'hD8,8'hA5,8'hD8,8'hB0,8'hD8,8'hA7,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD9,8'h88,8'hD8,8'hA5,8'hD9,8'h84,8'hD8,8'hA7,8'h00,8'h00,8'h00,8'h00},
    '{8'hD8,8'hA3,8'hD8,8'hAB,8'hD9,8'h86,8'hD8,8'hA7,8'hD8,8'hA1,8'h00,8'h00},
    '{8'hD9,8'h84,8'hD9,8'h83,8'hD9,8'h84,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD9,8'h81,8'hD9,8'h8A,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD8,8'hAA,8'hD9,8'h88,8'hD9,8'h82,8'hD9,8'h81,8'h00,8'h00,8'h00,8'h00},
    '{8'hD8,8'hA7,8'hD8,8'hB3,8'hD8,8'hAA,8'hD9,8'h85,8'hD8,8'hB1,8'h00,8'h00},
    '{8'hD8,8'hB5,8'hD9,8'h86,8'hD9,8'h81,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD8,8'hAC,8'hD8,8'hAF,8'hD9,8'h8A,8'hD8,8'hAF,8'h00,8'h00,8'h00,8'h00},
    '{8'hD9,8'h87,8'hD8,8'hB0,8'hD8,8'hA7,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD8,8'hA7,8'hD8,8'hB3,8'hD8,8'hAA,8'hD9,8'h88,8'hD8,8'hB1,8'hD8,8'hAF},
    '{8'hD8,8'hB5,8'hD8,8'hAF,8'hD8,8'hB1,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD8,8'hB5,8'hD8,8'hAD,8'hD9,8'h8A,8'hD8,8'hAD,8'h00,8'h00,8'h00,8'h00},
    '{8'hD8,8'hAE,8'hD8,8'hB7,8'hD8,8'hA3,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD9,8'h81,8'hD8,8'hA7,8'hD8,8'hB1,8'hD8,8'hBA,8'h00,8'h00,8'h00,8'h00},
    '{8'hD9,8'h88,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD8,8'hA3,8'hD9,8'h88,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'hD9,8'h84,8'hD9,8'h8A,8'hD8,8'hB3,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
  };

  function automatic out_t val_rec(input logic [7:0] c);
    out_t r;
    r = '0;
    r.rec_kind   = REC_VALUE;
    r.value_byte = c;
    return r;
  endfunction

  function automatic out_t end_rec(input logic [5:0] kind, input logic [15:0] line,
                                   input logic [15:0] col, input logic [9:0] len,
                                   input logic tr);
    out_t r;
    r = '0;
    r.rec_kind     = REC_END;
    r.token_kind   = kind;
    r.start_line   = line;
    r.start_column = col;
    r.value_length = len;
    r.truncated    = tr;
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER) || c[7];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_op_start(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == CH_EQ) || (c == CH_BANG) || (c == CH_LT) || (c == CH_GT);
  endfunction

  // Kind of a pending operator that closes on its own.
  function automatic logic [5:0] op1_kind(input logic [7:0] p);
    logic [5:0] k;
    case (p)
      CH_PLUS:  k = K_ADD;
      CH_MINUS: k = K_SUB;
      CH_STAR:  k = K_MUL;
      CH_SLASH: k = K_DIV;
      CH_EQ:    k = K_ASSIGN;
      CH_BANG:  k = K_ERROR;
      CH_LT:    k = K_LT;
      default:  k = K_GT;
    endcase
    return k;
  endfunction

  // Top bit set when c completes a two-byte operator with p.
  function automatic logic [6:0] op2_kind(input logic [7:0] p, input logic [7:0] c);
    logic [6:0] r;
    logic       eq;
    eq = (c == CH_EQ);
    r  = '0;
    case (p)
      CH_PLUS:  if (eq) r = {1'b1, K_ADDEQ};
      CH_MINUS: begin
        if (eq) r = {1'b1, K_SUBEQ};
        else if (c == CH_GT) r = {1'b1, K_ARROW};
      end
      CH_STAR: begin
        if (c == CH_STAR) r = {1'b1, K_POW};
        else if (eq) r = {1'b1, K_MULEQ};
      end
      CH_SLASH: if (eq) r = {1'b1, K_DIVEQ};
      CH_EQ:    if (eq) r = {1'b1, K_EQEQ};
      CH_BANG:  if (eq) r = {1'b1, K_NE};
      CH_LT:    if (eq) r = {1'b1, K_LE};
      default:  if (eq) r = {1'b1, K_GE};
    endcase
    return r;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      CH_PCT:    k = K_MOD;
      CH_LPAR:   k = K_LPAR;
      CH_RPAR:   k = K_RPAR;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LBRACK: k = K_LBRACK;
      CH_RBRACK: k = K_RBRACK;
      CH_COMMA:  k = K_COMMA;
      CH_SEMI:   k = K_SEMI;
      CH_COLON:  k = K_COLON;
      CH_DOT:    k = K_DOT;
      default:   k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] kw_kind(input kwbuf_t buf_in, input logic [3:0] fill);
    logic [5:0] k;
    logic       hit;
    k = K_IDENT;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      hit = (fill == KW_LEN[i]);
      for (int j = 0; j < KEYWORD_BYTES; j++) begin
        if ((4'(j) < KW_LEN[i]) && (buf_in[j] != KW_TABLE[i][j])) hit = 1'b0;
      end
      if (hit) k = K_KW0 + 6'(i);
    end
    return k;
  endfunction

endpackage

@@ hw/rtl/stl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_front
// Classifies each source byte, keeps the scan state and builds the list of
// records that the byte causes as one job for the back end.
// ----------------------------------------------------------------------------
module stl_front (
  input  logic          clk,
  input  logic          rst,
  input  stl_pkg::in_t  src,
  input  logic          take,
  output stl_pkg::job_t job
);

  stl_pkg::mode_t  mode, mode_next;
  logic [7:0]      pop, pop_next;
  logic [15:0]     cl, cl_next, cc, cc_next, tl, tl_next, tc, tc_next;
  logic [9:0]      len, len_next;
  logic            ovf, ovf_next, dot, dot_next, cq, cq_next, esc, esc_next;
  logic [3:0]      kwfill, kwfill_next;
  stl_pkg::kwbuf_t kw;
  logic            kw_we;
  logic [3:0]      kw_idx;
  logic [7:0]      kw_byte;

  stl_pkg::out_t   cand [stl_pkg::NUM_CAND];
  logic [stl_pkg::NUM_CAND-1:0] cand_en;

  always_comb begin
    logic [7:0] c;
    logic [7:0] cv;
    logic       cont, close, push, do_start;
    logic [6:0] k2;
    logic [5:0] ck, sk;
    c        = src.src_byte;
    cv       = c;
    cont     = 1'b0;
    close    = 1'b0;
    push     = 1'b0;
    do_start = 1'b0;
    k2       = '0;
    sk       = '0;
    mode_next = mode; pop_next = pop; cl_next = cl; cc_next = cc;
    tl_next = tl; tc_next = tc; len_next = len; ovf_next = ovf;
    dot_next = dot; cq_next = cq; esc_next = esc; kwfill_next = kwfill;
    kw_we = 1'b0; kw_idx = kwfill; kw_byte = c;
    for (int i = 0; i < stl_pkg::NUM_CAND; i++) cand[i] = '0;
    cand_en = '0;

    unique case (mode)
      stl_pkg::M_NUMBER: ck = dot ? stl_pkg::K_FLOAT : stl_pkg::K_INT;
      stl_pkg::M_STRING: ck = stl_pkg::K_STRING;
      stl_pkg::M_IDENT:  ck = stl_pkg::kw_kind(kw, kwfill);
      default:           ck = stl_pkg::K_INT;
    endcase

    if (src.end_of_source) begin
      if (mode == stl_pkg::M_OPER) begin
        cand_en[0] = 1'b1;
        cand[0]    = stl_pkg::val_rec(pop);
        cand_en[2] = 1'b1;
        cand[2]    = stl_pkg::end_rec(stl_pkg::op1_kind(pop), tl, tc, 10'd1, 1'b0);
      end else if (mode == stl_pkg::M_NUMBER || mode == stl_pkg::M_STRING ||
                   mode == stl_pkg::M_IDENT) begin
        cand_en[2] = 1'b1;
        cand[2]    = stl_pkg::end_rec(ck, tl, tc, len, ovf);
      end
      cand_en[6] = 1'b1;
      cand[6]    = stl_pkg::end_rec(stl_pkg::K_EOF, cl, cc, 10'd0, 1'b0);
      // start a fresh source
      mode_next = stl_pkg::M_IDLE; pop_next = '0; cl_next = 16'd1; cc_next = 16'd1;
      tl_next = 16'd1; tc_next = 16'd1; len_next = '0; ovf_next = 1'b0;
      dot_next = 1'b0; cq_next = 1'b0; esc_next = 1'b0; kwfill_next = '0;
    end else begin
      unique case (mode)
        stl_pkg::M_COMMENT: begin
          if (c == stl_pkg::CH_LF) mode_next = stl_pkg::M_IDLE;
        end
        stl_pkg::M_NUMBER: begin
          if (stl_pkg::is_digit(c) || c == stl_pkg::CH_DOT) begin
            cont = 1'b1;
            if (c == stl_pkg::CH_DOT) dot_next = 1'b1;
          end else begin
            close    = 1'b1;
            do_start = 1'b1;
          end
        end
        stl_pkg::M_IDENT: begin
          if (stl_pkg::is_letter(c) || stl_pkg::is_digit(c)) begin
            cont = 1'b1;
            push = 1'b1;
          end else begin
            close    = 1'b1;
            do_start = 1'b1;
          end
        end
        stl_pkg::M_STRING: begin
          if (esc) begin
            esc_next = 1'b0;
            cont     = 1'b1;
            if (c == stl_pkg::CH_N) cv = stl_pkg::CH_LF;
            else if (c == stl_pkg::CH_T) cv = stl_pkg::CH_TAB;
          end else if (c == stl_pkg::CH_BSLASH) begin
            esc_next = 1'b1;
          end else if (c == (cq ? stl_pkg::CH_SQUOTE : stl_pkg::CH_DQUOTE)) begin
            close = 1'b1;
          end else begin
            cont = 1'b1;
          end
        end
        stl_pkg::M_OPER: begin
          k2         = stl_pkg::op2_kind(pop, c);
          cand_en[0] = 1'b1;
          cand[0]    = stl_pkg::val_rec(pop);
          cand_en[2] = 1'b1;
          mode_next  = stl_pkg::M_IDLE;
          pop_next   = '0;
          if (k2[6]) begin
            cand_en[1] = 1'b1;
            cand[1]    = stl_pkg::val_rec(c);
            cand[2]    = stl_pkg::end_rec(k2[5:0], tl, tc, 10'd2, 1'b0);
          end else begin
            cand[2]  = stl_pkg::end_rec(stl_pkg::op1_kind(pop), tl, tc, 10'd1, 1'b0);
            do_start = 1'b1;
          end
        end
        default: begin
          mode_next = stl_pkg::M_IDLE;
          do_start  = 1'b1;
        end
      endcase

      if (close) begin
        cand_en[2] = 1'b1;
        cand[2]    = stl_pkg::end_rec(ck, tl, tc, len, ovf);
        mode_next  = stl_pkg::M_IDLE;
        pop_next   = '0;
      end

      if (cont) begin
        if (len < stl_pkg::MAX_TOKEN_BYTES) begin
          cand_en[0] = 1'b1;
          cand[0]    = stl_pkg::val_rec(cv);
          len_next   = len + 10'd1;
        end else begin
          ovf_next = 1'b1;
        end
      end

      if (push) begin
        if (kwfill < 4'(stl_pkg::KEYWORD_BYTES)) kw_we = 1'b1;
        if (kwfill <= 4'(stl_pkg::KEYWORD_BYTES)) kwfill_next = kwfill + 4'd1;
      end

      if (do_start && !stl_pkg::is_space(c)) begin
        if (c == stl_pkg::CH_HASH) begin
          mode_next = stl_pkg::M_COMMENT;
        end else begin
          tl_next = cl; tc_next = cc; len_next = '0; ovf_next = 1'b0;
          dot_next = 1'b0; esc_next = 1'b0; kwfill_next = '0;
          if (stl_pkg::is_digit(c)) begin
            mode_next  = stl_pkg::M_NUMBER;
            cand_en[3] = 1'b1;
            cand[3]    = stl_pkg::val_rec(c);
            len_next   = 10'd1;
          end else if (stl_pkg::is_letter(c)) begin
            mode_next   = stl_pkg::M_IDENT;
            cand_en[3]  = 1'b1;
            cand[3]     = stl_pkg::val_rec(c);
            len_next    = 10'd1;
            kw_we       = 1'b1;
            kw_idx      = '0;
            kwfill_next = 4'd1;
          end else if (c == stl_pkg::CH_DQUOTE || c == stl_pkg::CH_SQUOTE) begin
            mode_next = stl_pkg::M_STRING;
            cq_next   = (c == stl_pkg::CH_SQUOTE);
          end else if (stl_pkg::is_op_start(c)) begin
            mode_next = stl_pkg::M_OPER;
            pop_next  = c;
          end else begin
            sk         = stl_pkg::single_kind(c);
            cand_en[3] = 1'b1;
            cand_en[5] = 1'b1;
            if (sk == stl_pkg::K_COMMA || sk == stl_pkg::K_SEMI) begin
              cand[3]    = stl_pkg::val_rec(stl_pkg::AR_LEAD);
              cand_en[4] = 1'b1;
              cand[4]    = stl_pkg::val_rec((sk == stl_pkg::K_COMMA) ?
                                            stl_pkg::AR_COMMA : stl_pkg::AR_SEMI);
              cand[5]    = stl_pkg::end_rec(sk, cl, cc, 10'd2, 1'b0);
              len_next   = 10'd2;
            end else begin
              cand[3]  = stl_pkg::val_rec((sk == stl_pkg::K_ERROR) ? stl_pkg::CH_QMARK : c);
              cand[5]  = stl_pkg::end_rec(sk, cl, cc, 10'd1, 1'b0);
              len_next = 10'd1;
            end
          end
        end
      end

      if (c == stl_pkg::CH_LF) begin
        if (cl < stl_pkg::POS_MAX) cl_next = cl + 16'd1;
        cc_next = 16'd1;
      end else if (cc < stl_pkg::POS_MAX) begin
        cc_next = cc + 16'd1;
      end
    end
  end

  // Pack the enabled records in order.
  always_comb begin
    logic [2:0] n;
    n   = '0;
    job = '0;
    for (int i = 0; i < stl_pkg::NUM_CAND; i++) begin
      if (cand_en[i] && n < 3'(stl_pkg::MAX_RESULTS)) begin
        job.slot[n] = cand[i];
        n = n + 3'd1;
      end
    end
    job.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= stl_pkg::M_IDLE; pop <= '0; cl <= 16'd1; cc <= 16'd1;
      tl <= 16'd1; tc <= 16'd1; len <= '0; ovf <= 1'b0; dot <= 1'b0;
      cq <= 1'b0; esc <= 1'b0; kwfill <= '0;
    end else if (take) begin
      mode <= mode_next; pop <= pop_next; cl <= cl_next; cc <= cc_next;
      tl <= tl_next; tc <= tc_next; len <= len_next; ovf <= ovf_next;
      dot <= dot_next; cq <= cq_next; esc <= esc_next; kwfill <= kwfill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && kw_we) kw[kw_idx] <= kw_byte;
  end

endmodule

@@ hw/rtl/stl_job_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_job_fifo
// Two-entry queue of jobs between the classifier and the record emitter.
// ----------------------------------------------------------------------------
module stl_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  stl_pkg::job_t wdata,
  input  logic          pop,
  output stl_pkg::job_t rdata,
  output logic          full,
  output logic          empty
);

  stl_pkg::job_t mem [2];
  logic          wp, rp;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ hw/rtl/stl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stl_back
// Walks the head job one record per request and marks the last record.
// ----------------------------------------------------------------------------
module stl_back (
  input  logic          clk,
  input  logic          rst,
  input  stl_pkg::job_t head,
  input  logic          head_valid,
  output logic          head_pop,
  output stl_pkg::out_t rec,
  output logic          rec_valid,
  input  logic          rec_stall
);

  logic [2:0] idx;
  logic       last;

  assign last      = (idx == head.cnt - 3'd1);
  assign rec_valid = head_valid;
  assign head_pop  = head_valid && !rec_stall && last;

  always_comb begin
    rec             = head.slot[idx];
    rec.last_result = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (head_valid && !rec_stall) begin
      idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

endmodule

@@ hw/rtl/source_token_lexer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_lexer
// Streaming lexer: source bytes in, value-byte and token-end records out.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  src     | in  | src_valid/src_stall | in_t: src_byte, end_of_source
//  rec     | out | rec_valid/rec_stall | out_t: one record
//
// A byte is classified in the cycle it is taken; the records it causes (zero
// to five) go into a two-deep job queue and leave one per cycle from the head
// while rec is not stalled. Input is taken every cycle while the queue has
// room. Synchronous reset; no clearing pass.
// A stall on rec backs up the queue and then src_stall rises.
// ----------------------------------------------------------------------------
module source_token_lexer (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_stall,
  input  stl_pkg::in_t  src,
  output logic          rec_valid,
  input  logic          rec_stall,
  output stl_pkg::out_t rec
);

  stl_pkg::job_t job, head;
  logic          take, full, empty, head_pop;

  assign src_stall = full;
  assign take      = src_valid && !full;

  stl_front u_front (
    .clk  (clk),
    .rst  (rst),
    .src  (src),
    .take (take),
    .job  (job)
  );

  stl_job_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (take && (job.cnt != 3'd0)),
    .wdata (job),
    .pop   (head_pop),
    .rdata (head),
    .full  (full),
    .empty (empty)
  );

  stl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!empty),
    .head_pop   (head_pop),
    .rec        (rec),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall)
  );

endmodule
